// ----- rtl/dtt_pkg.sv -----
// ----------------------------------------------------------------------------
// dtt_pkg
// Shared types and codes for the delayed-action timer table.
// ----------------------------------------------------------------------------
package dtt_pkg;

    // request codes
    localparam logic [2:0] REQ_START_DAEMON = 3'd0;
    localparam logic [2:0] REQ_START_FUSE   = 3'd1;
    localparam logic [2:0] REQ_LENGTHEN     = 3'd2;
    localparam logic [2:0] REQ_EXTINGUISH   = 3'd3;
    localparam logic [2:0] REQ_FUSE_TICK    = 3'd4;
    localparam logic [2:0] REQ_DAEMON_TICK  = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_OK        = 2'd0;
    localparam logic [1:0] KIND_FIRED     = 2'd1;
    localparam logic [1:0] KIND_FULL      = 2'd2;
    localparam logic [1:0] KIND_NOT_FOUND = 2'd3;

    // firing limit per tick
    localparam int         MAX_FIRED   = 32;
    localparam int         FIRED_W     = 6;
    localparam logic [15:0] DAEMON_TIME = 16'hFFFF;

    typedef struct packed {
        logic [7:0]  handler;
        logic [15:0] arg;
        logic [15:0] turns_left;
    } dtt_entry_t;

endpackage

// ----- rtl/delayed_action_timer_table_core.sv -----
// ----------------------------------------------------------------------------
// delayed_action_timer_table_core
// Timer slot table held in a rotating ring of slot cells, walked once per
// request by a single edit point at the head of the ring.
// ----------------------------------------------------------------------------
//
//  channel  direction  payload                                       last word
//  s_       in         req_type, handler_id, action_arg, turns       -
//  m_       out        kind, fired_handler, fired_arg, last          m_last
//
//  Each request is accepted, then makes SLOT_COUNT ring shifts with the head
//  slot edited on each, then issues the terminator word. A pending output
//  word holds the ring only when the head slot has to emit; a full output
//  stage delays that shift and the terminator.
//  Reset empties every slot at once (handler cleared in each cell); no sweep.
//  s_ready is high only between requests.
//
module delayed_action_timer_table_core
    import dtt_pkg::*;
#(
    parameter int SLOT_COUNT = 32
)
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_req_type,
    input  logic [7:0]         s_handler_id,
    input  logic signed [15:0] s_action_arg,
    input  logic signed [15:0] s_turns,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_kind,
    output logic [7:0]         m_fired_handler,
    output logic signed [15:0] m_fired_arg,
    output logic               m_last
);

    // ring: cell 0 is the head, the edited slot re-enters at the tail
    dtt_entry_t ring [SLOT_COUNT];
    dtt_entry_t tail_entry;
    logic       shift;

    dtt_ctrl #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_handler_id    (s_handler_id),
        .s_action_arg    (s_action_arg),
        .s_turns         (s_turns),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_fired_handler (m_fired_handler),
        .m_fired_arg     (m_fired_arg),
        .m_last          (m_last),
        .head_entry      (ring[0]),
        .tail_entry      (tail_entry),
        .shift           (shift)
    );

    // after SLOT_COUNT shifts every slot is back in its own cell
    for (genvar k = 0; k < SLOT_COUNT; k++) begin : g_cell
        if (k == SLOT_COUNT - 1) begin : g_tail
            dtt_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .shift     (shift),
                .entry_in  (tail_entry),
                .entry_out (ring[k])
            );
        end else begin : g_mid
            dtt_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .shift     (shift),
                .entry_in  (ring[k+1]),
                .entry_out (ring[k])
            );
        end
    end

endmodule

// ----- rtl/dtt_cell.sv -----
// ----------------------------------------------------------------------------
// dtt_cell
// One timer slot of the rotating ring; loads its neighbour's word on shift.
// ----------------------------------------------------------------------------
module dtt_cell
    import dtt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       shift,
    input  dtt_entry_t entry_in,
    output dtt_entry_t entry_out
);

    logic [7:0]  handler_reg;
    logic [15:0] arg_reg;
    logic [15:0] turns_left_reg;

    // handler zero marks the slot empty, so it is cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            handler_reg <= 8'd0;
        end else if (shift) begin
            handler_reg <= entry_in.handler;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift) begin
            arg_reg        <= entry_in.arg;
            turns_left_reg <= entry_in.turns_left;
        end
    end

    assign entry_out.handler    = handler_reg;
    assign entry_out.arg        = arg_reg;
    assign entry_out.turns_left = turns_left_reg;

endmodule

// ----- rtl/dtt_ctrl.sv -----
// ----------------------------------------------------------------------------
// dtt_ctrl
// Request sequencer: edits the slot at the head of the ring on each shift and
// drives the output word register.
// ----------------------------------------------------------------------------
module dtt_ctrl
    import dtt_pkg::*;
#(
    parameter int SLOT_COUNT = 32
)
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_req_type,
    input  logic [7:0]         s_handler_id,
    input  logic signed [15:0] s_action_arg,
    input  logic signed [15:0] s_turns,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_kind,
    output logic [7:0]         m_fired_handler,
    output logic signed [15:0] m_fired_arg,
    output logic               m_last,
    input  dtt_entry_t         head_entry,
    output dtt_entry_t         tail_entry,
    output logic               shift
);

    localparam int CNT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_TERM = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               found_reg, found_next;
    logic [FIRED_W-1:0] fired_reg, fired_next;
    logic [2:0]         req_reg;
    logic [7:0]         hid_reg;
    logic [15:0]        arg_reg;
    logic [15:0]        turns_reg;

    logic               m_valid_reg, m_valid_next;
    logic [1:0]         m_kind_reg, m_kind_next;
    logic [7:0]         m_hand_reg, m_hand_next;
    logic [15:0]        m_arg_reg, m_arg_next;
    logic               m_last_reg, m_last_next;

    logic               out_free;
    logic               accept;
    logic               emit;
    logic               hit;
    logic               occupied;
    logic               fire_room;
    logic [16:0]        len_sum;
    logic [15:0]        len_sat;
    logic [1:0]         term_kind;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign occupied  = (head_entry.handler != 8'd0);
    assign fire_room = (fired_reg < FIRED_W'(MAX_FIRED));

    // saturating add for lengthen
    assign len_sum = {head_entry.turns_left[15], head_entry.turns_left}
                   + {turns_reg[15], turns_reg};
    assign len_sat = (len_sum[16] != len_sum[15])
                   ? (len_sum[16] ? 16'h8000 : 16'h7FFF) : len_sum[15:0];

    // head slot edit
    always_comb begin
        tail_entry = head_entry;
        emit       = 1'b0;
        hit        = 1'b0;
        case (req_reg)
            REQ_START_DAEMON, REQ_START_FUSE: begin
                if (!found_reg && !occupied) begin
                    hit                   = 1'b1;
                    tail_entry.handler    = hid_reg;
                    tail_entry.arg        = arg_reg;
                    tail_entry.turns_left = (req_reg == REQ_START_DAEMON)
                                          ? DAEMON_TIME : turns_reg;
                end
            end
            REQ_LENGTHEN: begin
                if (!found_reg && hid_reg != 8'd0 && head_entry.handler == hid_reg) begin
                    hit                   = 1'b1;
                    tail_entry.turns_left = len_sat;
                end
            end
            REQ_EXTINGUISH: begin
                if (!found_reg && hid_reg != 8'd0 && head_entry.handler == hid_reg) begin
                    hit                = 1'b1;
                    tail_entry.handler = 8'd0;
                end
            end
            REQ_FUSE_TICK: begin
                if (occupied && $signed(head_entry.turns_left) > 16'sd0) begin
                    if (head_entry.turns_left == 16'd1) begin
                        if (fire_room) begin
                            emit                  = 1'b1;
                            tail_entry.handler    = 8'd0;
                            tail_entry.turns_left = 16'd0;
                        end
                    end else begin
                        tail_entry.turns_left = head_entry.turns_left - 16'd1;
                    end
                end
            end
            REQ_DAEMON_TICK: begin
                if (occupied && head_entry.turns_left == DAEMON_TIME && fire_room) begin
                    emit = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        case (req_reg)
            REQ_START_DAEMON, REQ_START_FUSE: term_kind = found_reg ? KIND_OK : KIND_FULL;
            REQ_LENGTHEN, REQ_EXTINGUISH:     term_kind = found_reg ? KIND_OK : KIND_NOT_FOUND;
            default:                          term_kind = KIND_OK;
        endcase
    end

    assign shift = (state_reg == ST_WALK) && (!emit || out_free);

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        found_next   = found_reg;
        fired_next   = fired_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_kind_next  = m_kind_reg;
        m_hand_next  = m_hand_reg;
        m_arg_next   = m_arg_reg;
        m_last_next  = m_last_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_WALK;
                    cnt_next   = '0;
                    found_next = 1'b0;
                    fired_next = '0;
                end
            end
            ST_WALK: begin
                if (shift) begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (hit) begin
                        found_next = 1'b1;
                    end
                    if (emit) begin
                        fired_next   = fired_reg + FIRED_W'(1);
                        m_valid_next = 1'b1;
                        m_kind_next  = KIND_FIRED;
                        m_hand_next  = head_entry.handler;
                        m_arg_next   = head_entry.arg;
                        m_last_next  = 1'b0;
                    end
                    if (cnt_reg == CNT_W'(SLOT_COUNT - 1)) begin
                        state_next = ST_TERM;
                    end
                end
            end
            ST_TERM: begin
                if (out_free) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                    m_kind_next  = term_kind;
                    m_hand_next  = 8'd0;
                    m_arg_next   = 16'd0;
                    m_last_next  = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            found_reg   <= 1'b0;
            fired_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            found_reg   <= found_next;
            fired_reg   <= fired_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_kind_reg <= m_kind_next;
        m_hand_reg <= m_hand_next;
        m_arg_reg  <= m_arg_next;
        m_last_reg <= m_last_next;
        if (accept) begin
            req_reg   <= s_req_type;
            hid_reg   <= s_handler_id;
            arg_reg   <= s_action_arg;
            turns_reg <= s_turns;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_kind          = m_kind_reg;
    assign m_fired_handler = m_hand_reg;
    assign m_fired_arg     = m_arg_reg;
    assign m_last          = m_last_reg;

endmodule

// ----- verif/delayed_action_timer_table_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// delayed_action_timer_table_core_tb
// Self-checking bench for the timer slot table: a slot-accurate copy of the
// table predicts every word of every request, and a monitor compares each
// word leaving the m_ channel with the oldest word still due.
// ----------------------------------------------------------------------------
module delayed_action_timer_table_core_tb
    import dtt_pkg::*;
();

    localparam int          SLOTS        = 32;
    localparam int          LIMIT_CYCLES = 600000;
    localparam int          MAX_PRINTED  = 60;
    // request codes the block has no use for; it answers them with a plain ok
    localparam logic [2:0]  REQ_SPARE_6  = 3'd6;
    localparam logic [2:0]  REQ_SPARE_7  = 3'd7;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         handler;
        logic signed [15:0] arg;
        logic               last;
    } result_word_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [2:0]         s_req_type;
    logic [7:0]         s_handler_id;
    logic signed [15:0] s_action_arg;
    logic signed [15:0] s_turns;
    logic               m_valid;
    logic               m_ready;
    logic [1:0]         m_kind;
    logic [7:0]         m_fired_handler;
    logic signed [15:0] m_fired_arg;
    logic               m_last;

    result_word_t       words_due   [$];

    delayed_action_timer_table_core #(
        .SLOT_COUNT(SLOTS)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_handler_id   (s_handler_id),
        .s_action_arg   (s_action_arg),
        .s_turns        (s_turns),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_fired_handler(m_fired_handler),
        .m_fired_arg    (m_fired_arg),
        .m_last         (m_last)
    );

    // ------------------------------------------------------------------
    // Clock, watchdog and receiver back-pressure
    // ------------------------------------------------------------------
    always #5 aclk = ~aclk;

    int cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d words still due", cycle_count,
                     words_due.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // idle percentages per side; changed between stimulus phases
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // ------------------------------------------------------------------
    // Table copy and word predictor
    // ------------------------------------------------------------------
    // Arg and time of a free slot are never read, so their reset value does
    // not matter here.
    logic [7:0]         tbl_handler [SLOTS];
    logic signed [15:0] tbl_arg     [SLOTS];
    logic signed [15:0] tbl_time    [SLOTS];

    function automatic int slots_in_use();
        int n;
        n = 0;
        for (int i = 0; i < SLOTS; i++)
            if (tbl_handler[i] != 8'd0) n++;
        return n;
    endfunction

    // handler of a random live slot, or any non-zero id on an empty table
    function automatic logic [7:0] some_live_handler();
        int pick;
        if (slots_in_use() == 0)
            return 8'($urandom_range(1, 255));
        do pick = $urandom_range(SLOTS - 1); while (tbl_handler[pick] == 8'd0);
        return tbl_handler[pick];
    endfunction

    // Applies one accepted request to the table copy and queues the words it
    // must produce, in order.
    task automatic timer_table_predict(input logic [2:0] req, input logic [7:0] hid,
                                       input logic signed [15:0] arg,
                                       input logic signed [15:0] trn);
        int idx;
        int fired;
        int sum;
        idx   = -1;
        fired = 0;
        case (req)
            REQ_START_DAEMON, REQ_START_FUSE: begin
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (tbl_handler[i] == 8'd0) idx = i;
                if (idx < 0) begin
                    words_due.push_back('{KIND_FULL, 8'd0, 16'sd0, 1'b1});
                end else begin
                    // an id of zero still writes the slot, which stays free
                    tbl_handler[idx] = hid;
                    tbl_arg[idx]     = arg;
                    tbl_time[idx]    = (req == REQ_START_DAEMON) ? DAEMON_TIME : trn;
                    words_due.push_back('{KIND_OK, 8'd0, 16'sd0, 1'b1});
                end
            end
            REQ_LENGTHEN, REQ_EXTINGUISH: begin
                if (hid != 8'd0)
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (tbl_handler[i] == hid) idx = i;
                if (idx < 0) begin
                    words_due.push_back('{KIND_NOT_FOUND, 8'd0, 16'sd0, 1'b1});
                end else begin
                    if (req == REQ_LENGTHEN) begin
                        sum = int'(tbl_time[idx]) + int'(trn);
                        if (sum > 32767)  sum = 32767;
                        if (sum < -32768) sum = -32768;
                        tbl_time[idx] = 16'(sum);
                    end else begin
                        tbl_handler[idx] = 8'd0;
                    end
                    words_due.push_back('{KIND_OK, 8'd0, 16'sd0, 1'b1});
                end
            end
            REQ_FUSE_TICK: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (tbl_handler[i] != 8'd0 && tbl_time[i] > 0) begin
                        if (tbl_time[i] != 1) begin
                            tbl_time[i] = tbl_time[i] - 16'sd1;
                        end else if (fired < MAX_FIRED) begin
                            tbl_time[i] = 16'sd0;
                            words_due.push_back('{KIND_FIRED, tbl_handler[i], tbl_arg[i],
                                                  1'b0});
                            tbl_handler[i] = 8'd0;
                            fired++;
                        end
                    end
                end
                words_due.push_back('{KIND_OK, 8'd0, 16'sd0, 1'b1});
            end
            REQ_DAEMON_TICK: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (tbl_handler[i] != 8'd0 && tbl_time[i] == DAEMON_TIME
                        && fired < MAX_FIRED) begin
                        words_due.push_back('{KIND_FIRED, tbl_handler[i], tbl_arg[i],
                                              1'b0});
                        fired++;
                    end
                end
                words_due.push_back('{KIND_OK, 8'd0, 16'sd0, 1'b1});
            end
            default: begin
                words_due.push_back('{KIND_OK, 8'd0, 16'sd0, 1'b1});
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Mismatch reporting and result monitor
    // ------------------------------------------------------------------
    int mismatch_count = 0;

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("[%0t] %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    endtask

    // Sampled at the rising edge, before any of this edge's updates land.
    always @(posedge aclk) begin : check_words
        result_word_t due;
        if (aresetn && m_valid && m_ready) begin
            if (words_due.size() == 0) begin
                report_mismatch("word with nothing due", 0,
                                32'({m_kind, m_fired_handler, m_fired_arg, m_last}));
            end else begin
                due = words_due.pop_front();
                if (m_kind !== due.kind)
                    report_mismatch("kind", 32'(due.kind), 32'(m_kind));
                if (m_fired_handler !== due.handler)
                    report_mismatch("fired_handler", 32'(due.handler),
                                    32'(m_fired_handler));
                if (m_fired_arg !== due.arg)
                    report_mismatch("fired_arg", 32'(16'(due.arg)), 32'(16'(m_fired_arg)));
                if (m_last !== due.last)
                    report_mismatch("last", 32'(due.last), 32'(m_last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    // Called just after a rising edge. Valid is left high after acceptance so
    // back-to-back words never drop and re-raise it in one step; an idle
    // stretch, when drawn, lowers it first.
    task automatic send_request(input logic [2:0] req, input logic [7:0] hid,
                                input logic signed [15:0] arg,
                                input logic signed [15:0] trn);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= req;
        s_handler_id <= hid;
        s_action_arg <= arg;
        s_turns      <= trn;
        do @(posedge aclk); while (!s_ready);
        timer_table_predict(req, hid, arg, trn);
    endtask

    // Holds the sender off until every predicted word has been seen.
    task automatic wait_words_drained();
        s_valid <= 1'b0;
        while (words_due.size() != 0) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Field extremes, every request code and the corner cases, on a table
    // that ends up empty again.
    task automatic test_directed();
        send_request(REQ_DAEMON_TICK, 8'd1, 16'sd0, 16'sd0);           // empty table
        send_request(REQ_FUSE_TICK, 8'd1, 16'sd0, 16'sd0);
        send_request(REQ_START_DAEMON, 8'hFF, 16'sh7FFF, 16'sd0);
        send_request(REQ_START_FUSE, 8'd1, -16'sh8000, 16'sd1);
        send_request(REQ_START_FUSE, 8'd2, 16'sh1234, -16'sd1);        // turns into daemon
        send_request(REQ_START_FUSE, 8'd3, 16'sd0, 16'sd0);            // dormant until lengthened
        send_request(REQ_START_FUSE, 8'd4, -16'sd1, -16'sh8000);       // never fires
        send_request(REQ_START_FUSE, 8'd5, 16'sh5A5A, 16'sh7FFF);
        send_request(REQ_START_DAEMON, 8'd0, 16'sh5555, 16'sd0);       // slot stays free
        send_request(REQ_LENGTHEN, 8'd5, 16'sd0, 16'sh7FFF);           // clips high
        send_request(REQ_LENGTHEN, 8'd4, 16'sd0, -16'sh8000);          // clips low
        send_request(REQ_LENGTHEN, 8'd0, 16'sd0, 16'sd1);              // id zero
        send_request(REQ_EXTINGUISH, 8'd0, 16'sd0, 16'sd0);
        send_request(REQ_LENGTHEN, 8'd99, 16'sd0, 16'sd1);             // no such handler
        send_request(REQ_EXTINGUISH, 8'd99, 16'sd0, 16'sd0);
        send_request(REQ_SPARE_6, 8'hFF, -16'sd1, -16'sd1);
        send_request(REQ_SPARE_7, 8'hFF, -16'sd1, -16'sd1);
        send_request(REQ_DAEMON_TICK, 8'd1, 16'sd0, 16'sd0);
        send_request(REQ_FUSE_TICK, 8'd1, 16'sd0, 16'sd0);
        send_request(REQ_LENGTHEN, 8'd3, 16'sd0, 16'sd2);              // dormant fuse revived
        send_request(REQ_FUSE_TICK, 8'd1, 16'sd0, 16'sd0);
        send_request(REQ_FUSE_TICK, 8'd1, 16'sd0, 16'sd0);
        send_request(REQ_EXTINGUISH, 8'hFF, 16'sd0, 16'sd0);
        send_request(REQ_EXTINGUISH, 8'd2, 16'sd0, 16'sd0);
        send_request(REQ_EXTINGUISH, 8'd5, 16'sd0, 16'sd0);
        send_request(REQ_EXTINGUISH, 8'd4, 16'sd0, 16'sd0);
    endtask

    // Fill every slot with a daemon, bounce both start kinds off the full
    // table, fire all slots in one tick (the longest burst), then clear.
    task automatic test_table_full();
        logic [7:0] ids [SLOTS];
        wait_words_drained();
        while (slots_in_use() < SLOTS)
            send_request(REQ_START_DAEMON, 8'($urandom_range(1, 255)), 16'($urandom),
                         16'($urandom));
        send_request(REQ_START_FUSE, 8'd7, 16'($urandom), 16'sd1);
        send_request(REQ_START_DAEMON, 8'd8, 16'($urandom), 16'sd0);
        send_request(REQ_DAEMON_TICK, 8'($urandom), 16'($urandom), 16'($urandom));
        send_request(REQ_FUSE_TICK, 8'($urandom), 16'($urandom), 16'($urandom));
        ids = tbl_handler;
        foreach (ids[i])
            send_request(REQ_EXTINGUISH, ids[i], 16'($urandom), 16'($urandom));
        wait_words_drained();
    endtask

    // Mostly well-formed traffic over a small id pool so that lookups hit and
    // fuses actually burn down; a slice of fully random words as noise.
    task automatic test_random(input int n_items);
        logic [2:0]         req;
        logic [7:0]         hid;
        logic signed [15:0] arg;
        logic signed [15:0] trn;
        int                 pick;
        repeat (n_items) begin
            pick = $urandom_range(99);
            hid  = 8'($urandom_range(1, 12));
            arg  = 16'($urandom);
            trn  = 16'($urandom_range(1, 6));
            if (pick < 28)      req = REQ_START_FUSE;
            else if (pick < 38) req = REQ_START_DAEMON;
            else if (pick < 48) req = REQ_LENGTHEN;
            else if (pick < 60) req = REQ_EXTINGUISH;
            else if (pick < 84) req = REQ_FUSE_TICK;
            else if (pick < 92) req = REQ_DAEMON_TICK;
            else                req = 3'($urandom);
            if (pick >= 92) begin
                // noise word: every field drawn over its full width
                hid = 8'($urandom);
                trn = 16'($urandom);
            end else begin
                // keep the table from sitting full for long
                if ((req == REQ_START_FUSE || req == REQ_START_DAEMON)
                    && slots_in_use() > 24 && $urandom_range(1) == 1)
                    req = REQ_EXTINGUISH;
                if (req == REQ_START_FUSE || req == REQ_START_DAEMON) begin
                    if ($urandom_range(19) == 0) hid = 8'($urandom);
                    pick = $urandom_range(19);
                    if (pick < 2)      trn = -16'sd1;
                    else if (pick < 3) trn = 16'sd0;
                    else if (pick < 6) trn = 16'($urandom);
                end else if (req == REQ_LENGTHEN || req == REQ_EXTINGUISH) begin
                    if ($urandom_range(9) < 8) hid = some_live_handler();
                    if ($urandom_range(4) == 0) trn = 16'($urandom);
                    else                        trn = 16'(int'($urandom_range(8)) - 4);
                end
            end
            send_request(req, hid, arg, trn);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_req_type   <= REQ_FUSE_TICK;
        s_handler_id <= 8'd0;
        s_action_arg <= 16'sd0;
        s_turns      <= 16'sd0;
        foreach (tbl_handler[i]) begin
            tbl_handler[i] = 8'd0;
            tbl_arg[i]     = 16'sd0;
            tbl_time[i]    = 16'sd0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sender sparse-ish, receiver stalling more than half the time
        tx_idle_pct = 27;
        rx_idle_pct = 57;
        test_directed();
        test_table_full();
        test_random(39);

        // the other way round
        tx_idle_pct = 57;
        rx_idle_pct = 27;
        test_random(39);

        // flat out on both sides
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random(39);

        // all words in, then wait on to catch stray words
        wait_words_drained();
        repeat (SLOTS + 8) @(posedge aclk);
        if (words_due.size() != 0)
            report_mismatch("words still due", 0, words_due.size());

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
